>>> hw/rtl/lmsp_pkg.sv
// Shared constants and types for the LED matrix scan PWM driver.
package lmsp_pkg;

    localparam int TILE_SIZE      = 10;
    localparam int TILES_PER_SIDE = 3;
    localparam int LINE_BITS      = 64;

    localparam int PANEL_SIDE   = TILE_SIZE * TILES_PER_SIDE;
    localparam int FRAME_PIXELS = PANEL_SIDE * PANEL_SIDE;
    localparam int STORE_DEPTH  = 2 * FRAME_PIXELS;
    localparam int NUM_TILES    = TILES_PER_SIDE * TILES_PER_SIDE;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int ROW_W   = $clog2(TILE_SIZE);
    localparam int TBLK_W  = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;
    localparam int POS_W   = $clog2(3 * TILE_SIZE + 66);
    localparam int PIXEL_W = 24;

    // Field widths fixed by the interface
    localparam int MODE_W    = 2;
    localparam int COORD_W   = 5;
    localparam int LEVEL_W   = 8;
    localparam int TILE_IDX_W = 4;
    localparam int SCAN_ROW_W = 4;
    localparam int STEP_W    = 8;
    localparam int LINE_W    = 64;
    localparam int DEPTH_W   = 9;
    localparam int OFFS_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;

    // Input item kinds
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET  = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET   = 9'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX     = 9'd256;
    localparam logic [OFFS_W-1:0]  COL_OFF_RESET = 6'd0;
    localparam logic [OFFS_W-1:0]  ROW_OFF_RESET = 6'd32;

    typedef logic [LINE_BITS-1:0] line_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [PIXEL_W-1:0]   pixel_t;

endpackage

>>> hw/rtl/led_matrix_scan_pwm_driver_core.sv
// Top level of the row-scanned, double-buffered RGB LED panel PWM driver.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  s_axis    | s_axis_tvalid/s_axis_tready  | tuser: mode; tdata: row, col, r, g, b
//  m_axis    | m_axis_tvalid/m_axis_tready  | tdata: tile, line word, row, step; tlast
//  cfg       | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// A scan tick reads every pixel of the scanned row in turn: the frame
// memory has a single read port and every pixel of the scanned row is
// read once.
// After reset a clearing pass zeroes the frame memory, one entry a cycle;
// no input beat is taken meanwhile, config is.
// A stalled output holds the tile sequencer at the end of the next tile;
// the final line word waits in the output register while the next input
// beat is already taken.
module led_matrix_scan_pwm_driver_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [4:0] pixel_row, [9:5] pixel_col, [17:10] red_level,
    // [25:18] green_level, [33:26] blue_level, [39:34] zero
    input  logic [lmsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [lmsp_pkg::MODE_W-1:0]     s_axis_tuser,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] tile_index, [67:4] line_word, [71:68] scan_row, [79:72] color_step
    output logic [lmsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmsp_pkg::DEPTH_W-1:0]    cfg_data
);

    import lmsp_pkg::*;

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(TILE_SIZE - 1);
    localparam logic [TBLK_W-1:0] LAST_BLK  = TBLK_W'(TILES_PER_SIDE - 1);
    localparam logic [TILE_IDX_W-1:0] LAST_TILE = TILE_IDX_W'(NUM_TILES - 1);
    localparam addr_t FRAME_OFF = ADDR_W'(FRAME_PIXELS);
    localparam addr_t LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    // Input fields
    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;
    logic [LEVEL_W-1:0] in_red;
    logic [LEVEL_W-1:0] in_green;
    logic [LEVEL_W-1:0] in_blue;

    assign in_row   = s_axis_tdata[4:0];
    assign in_col   = s_axis_tdata[9:5];
    assign in_red   = s_axis_tdata[17:10];
    assign in_green = s_axis_tdata[25:18];
    assign in_blue  = s_axis_tdata[33:26];

    // Configuration
    logic [DEPTH_W-1:0] depth_reg;
    logic [OFFS_W-1:0]  col_off_reg;
    logic [OFFS_W-1:0]  row_off_reg;

    // Scan state
    logic               sel_reg, sel_next;
    logic               pend_reg, pend_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // Clearing pass
    logic  clr_reg;
    addr_t clr_addr_reg;

    // Read issue stage
    logic                  iss_active_reg, iss_active_next;
    logic [TBLK_W-1:0]     iss_tr_reg, iss_tr_next;
    logic [TBLK_W-1:0]     iss_tc_reg, iss_tc_next;
    logic [ROW_W-1:0]      iss_col_reg, iss_col_next;
    logic [TILE_IDX_W-1:0] iss_tile_reg, iss_tile_next;

    // Read data stage
    logic                  dat_valid_reg, dat_valid_next;
    logic [ROW_W-1:0]      dat_col_reg;
    logic [TILE_IDX_W-1:0] dat_tile_reg;
    line_t                 acc_reg;

    // Output register
    logic                  out_valid_reg;
    logic [TILE_IDX_W-1:0] out_tile_reg;
    line_t                 out_line_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [STEP_W-1:0]     out_step_reg;
    logic                  out_last_reg;

    logic   in_fire;
    logic   busy;
    logic   stall;
    logic   iss_fire;
    logic   dat_fire;
    logic   tile_done;
    logic   pix_we;
    logic   ram_we;
    addr_t  ram_waddr;
    pixel_t ram_wdata;
    addr_t  pix_addr;
    addr_t  rd_addr;
    pixel_t rd_data;

    logic [DEPTH_W-1:0] depth_clamp;
    logic [DEPTH_W-1:0] step_inc;
    logic               step_wrap;

    logic [POS_W-1:0] row_pos;
    logic [POS_W-1:0] col_pos;
    logic [2:0]       color_bits;
    line_t            row_bit;
    line_t            col_bits;
    line_t            word_now;

    assign busy          = iss_active_reg | dat_valid_reg;
    assign s_axis_tready = ~clr_reg & ~busy;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= DEPTH_RESET;
            col_off_reg <= COL_OFF_RESET;
            row_off_reg <= ROW_OFF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLOR_DEPTH: depth_reg   <= cfg_data;
                CFG_COL_OFFSET:  col_off_reg <= cfg_data[OFFS_W-1:0];
                CFG_ROW_OFFSET:  row_off_reg <= cfg_data[OFFS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Row and PWM step advance on a tick; a pending swap lands when the step wraps
    assign depth_clamp = (depth_reg > DEPTH_MAX) ? DEPTH_MAX : depth_reg;
    assign step_inc    = {1'b0, step_reg} + DEPTH_W'(1);
    assign step_wrap   = (step_inc >= depth_clamp) | step_inc[DEPTH_W-1];

    always_comb
    begin
        sel_next  = sel_reg;
        pend_next = pend_reg;
        row_next  = row_reg;
        step_next = step_reg;
        if (in_fire && s_axis_tuser == MODE_SWAP)
        begin
            pend_next = 1'b1;
        end
        else if (in_fire && s_axis_tuser == MODE_TICK)
        begin
            if (row_reg == LAST_ROW)
            begin
                row_next = '0;
                if (step_wrap)
                begin
                    step_next = '0;
                    if (pend_reg)
                    begin
                        sel_next  = ~sel_reg;
                        pend_next = 1'b0;
                    end
                end
                else
                begin
                    step_next = step_inc[STEP_W-1:0];
                end
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= 1'b0;
            pend_reg <= 1'b0;
            row_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            sel_reg  <= sel_next;
            pend_reg <= pend_next;
            row_reg  <= row_next;
            step_reg <= step_next;
        end
    end

    // Clearing pass after reset: zero every entry of both frames
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // Pixel writes land in the frame not on display; off-panel writes drop
    assign pix_we = in_fire && s_axis_tuser == MODE_WRITE &&
                    int'(in_row) < PANEL_SIDE && int'(in_col) < PANEL_SIDE;
    assign pix_addr = (sel_reg ? addr_t'(0) : FRAME_OFF) +
                      ADDR_W'(in_row) * ADDR_W'(PANEL_SIDE) + ADDR_W'(in_col);

    assign ram_we    = clr_reg | pix_we;
    assign ram_waddr = clr_reg ? clr_addr_reg : pix_addr;
    assign ram_wdata = clr_reg ? pixel_t'(0) : {in_red, in_green, in_blue};

    // Tile sequencer: one pixel read per cycle unless the output stalls, tile by tile, column by column
    assign tile_done = dat_valid_reg && dat_col_reg == LAST_ROW;
    assign stall     = tile_done & out_valid_reg & ~m_axis_tready;
    assign iss_fire  = iss_active_reg & ~stall;
    assign dat_fire  = dat_valid_reg & ~stall;

    assign rd_addr = (sel_reg ? FRAME_OFF : addr_t'(0)) +
                     (ADDR_W'(iss_tr_reg) * ADDR_W'(TILE_SIZE) + ADDR_W'(row_reg)) *
                     ADDR_W'(PANEL_SIDE) +
                     ADDR_W'(iss_tc_reg) * ADDR_W'(TILE_SIZE) + ADDR_W'(iss_col_reg);

    always_comb
    begin
        iss_active_next = iss_active_reg;
        iss_tr_next     = iss_tr_reg;
        iss_tc_next     = iss_tc_reg;
        iss_col_next    = iss_col_reg;
        iss_tile_next   = iss_tile_reg;
        if (in_fire && s_axis_tuser == MODE_TICK)
        begin
            iss_active_next = 1'b1;
            iss_tr_next     = '0;
            iss_tc_next     = '0;
            iss_col_next    = '0;
            iss_tile_next   = '0;
        end
        else if (iss_fire)
        begin
            if (iss_col_reg == LAST_ROW)
            begin
                iss_col_next  = '0;
                iss_tile_next = iss_tile_reg + TILE_IDX_W'(1);
                if (iss_tc_reg == LAST_BLK)
                begin
                    iss_tc_next = '0;
                    if (iss_tr_reg == LAST_BLK)
                    begin
                        iss_active_next = 1'b0;
                    end
                    else
                    begin
                        iss_tr_next = iss_tr_reg + TBLK_W'(1);
                    end
                end
                else
                begin
                    iss_tc_next = iss_tc_reg + TBLK_W'(1);
                end
            end
            else
            begin
                iss_col_next = iss_col_reg + ROW_W'(1);
            end
        end
    end

    // Hold the data stage on a stall; otherwise it follows the issue stage
    assign dat_valid_next = stall ? dat_valid_reg : iss_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_active_reg <= 1'b0;
            iss_tr_reg     <= '0;
            iss_tc_reg     <= '0;
            iss_col_reg    <= '0;
            iss_tile_reg   <= '0;
            dat_valid_reg  <= 1'b0;
        end
        else
        begin
            iss_active_reg <= iss_active_next;
            iss_tr_reg     <= iss_tr_next;
            iss_tc_reg     <= iss_tc_next;
            iss_col_reg    <= iss_col_next;
            iss_tile_reg   <= iss_tile_next;
            dat_valid_reg  <= dat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_fire)
        begin
            dat_col_reg  <= iss_col_reg;
            dat_tile_reg <= iss_tile_reg;
        end
    end

    // Line word assembly: green, blue, red bits above the column base;
    // bits past the top of the word drop out of the shift
    assign color_bits = {rd_data[23:16] > step_reg,
                         rd_data[7:0]   > step_reg,
                         rd_data[15:8]  > step_reg};
    assign col_pos  = POS_W'(dat_col_reg) * POS_W'(3) + POS_W'(col_off_reg);
    assign row_pos  = POS_W'(row_reg) + POS_W'(row_off_reg);
    assign col_bits = line_t'(color_bits) << col_pos;
    assign row_bit  = line_t'(1) << row_pos;
    assign word_now = ((dat_col_reg == '0) ? row_bit : acc_reg) | col_bits;

    always_ff @(posedge clk)
    begin
        if (dat_fire)
        begin
            acc_reg <= word_now;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dat_fire && tile_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dat_fire && tile_done)
        begin
            out_tile_reg <= dat_tile_reg;
            out_line_reg <= word_now;
            out_row_reg  <= row_reg;
            out_step_reg <= step_reg;
            out_last_reg <= (dat_tile_reg == LAST_TILE);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_step_reg, SCAN_ROW_W'(out_row_reg),
                            LINE_W'(out_line_reg), out_tile_reg};

    lmsp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (iss_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

>>> hw/rtl/lmsp_ram.sv
// Generic simple dual-port RAM with registered read data.
module lmsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> verif/led_matrix_scan_pwm_driver_core_tb.sv
// Self-checking testbench for the LED matrix scan PWM driver core.
module led_matrix_scan_pwm_driver_core_tb;
    import lmsp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 150;   // settle time after a tick, with margin
    localparam int LONG_HOLD    = 1500;
    localparam int MAX_REPORTS  = 40;
    localparam int NUM_PHASES   = 7;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;

    // Codes the package leaves undefined; the block must ignore them
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [IN_DATA_W-1:0] data;
    } panel_item_t;

    typedef struct packed {
        logic [TILE_IDX_W-1:0] tile;
        line_t                 line;
        logic [SCAN_ROW_W-1:0] row;
        logic [STEP_W-1:0]     step;
        logic                  last;
    } line_beat_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [MODE_W-1:0]      s_axis_tuser  = MODE_WRITE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = CFG_COLOR_DEPTH;
    logic [DEPTH_W-1:0]     cfg_data      = '0;

    // Phase settings, extremes included
    int phase_depth [NUM_PHASES] = '{2, 0, 3, 256, 511, 4, 1};
    int phase_col   [NUM_PHASES] = '{0, 34, 63, 5, 1, 17, 0};
    int phase_row   [NUM_PHASES] = '{32, 54, 0, 63, 10, 40, 32};
    int phase_items [NUM_PHASES] = '{80, 70, 70, 60, 40, 80, 50};

    // Shadow of the panel state
    pixel_t frame_mem [STORE_DEPTH];
    logic   shown_frame;
    logic   swap_armed;
    int     scan_row_cnt;
    int     pwm_step;
    int     pwm_depth;
    int     col_offset;
    int     row_offset;

    panel_item_t pending_items [$];
    line_beat_t  expected_lines [$];
    line_beat_t  want_beat;
    panel_item_t next_item;

    int  items_pushed = 0;
    int  items_taken  = 0;
    int  lines_seen   = 0;
    int  cfg_beats    = 0;
    int  mismatches   = 0;
    int  cycle_count  = 0;
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int  in_gap   = 0;
    int  out_gap  = 0;
    int  hold_left = 0;
    bit  in_calm  = 1'b0;
    bit  out_calm = 1'b0;
    bit  long_hold_done = 1'b0;

    led_matrix_scan_pwm_driver_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic line_t bit_at(int pos);
        // drop positions past the end of the line word
        return (pos < LINE_BITS) ? (line_t'(1) << pos) : '0;
    endfunction

    // Advance row and PWM step, apply a pending swap on the step wrap,
    // then queue one line word per tile.
    function automatic void run_scan_tick();
        int     depth_cap;
        int     prow;
        int     base;
        int     tile_no;
        pixel_t px;
        line_beat_t beat;
        depth_cap = (pwm_depth > 256) ? 256 : pwm_depth;
        scan_row_cnt++;
        if (scan_row_cnt >= TILE_SIZE)
        begin
            scan_row_cnt = 0;
            pwm_step++;
            if (pwm_step >= depth_cap || pwm_step > 255)
            begin
                pwm_step = 0;
                if (swap_armed)
                begin
                    shown_frame = ~shown_frame;
                    swap_armed  = 1'b0;
                end
            end
        end
        for (int tr = 0; tr < TILES_PER_SIDE; tr++)
        begin
            for (int tc = 0; tc < TILES_PER_SIDE; tc++)
            begin
                tile_no   = tr * TILES_PER_SIDE + tc;
                prow      = tr * TILE_SIZE + scan_row_cnt;
                beat.tile = TILE_IDX_W'(tile_no);
                beat.line = bit_at(scan_row_cnt + row_offset);
                for (int col = 0; col < TILE_SIZE; col++)
                begin
                    px = frame_mem[(shown_frame ? FRAME_PIXELS : 0) + prow * PANEL_SIDE
                                   + tc * TILE_SIZE + col];
                    base = col * 3 + col_offset;
                    if (px[15:8] > pwm_step)
                        beat.line |= bit_at(base);
                    if (px[7:0] > pwm_step)
                        beat.line |= bit_at(base + 1);
                    if (px[23:16] > pwm_step)
                        beat.line |= bit_at(base + 2);
                end
                beat.row  = SCAN_ROW_W'(scan_row_cnt);
                beat.step = STEP_W'(pwm_step);
                beat.last = (tile_no == NUM_TILES - 1);
                expected_lines.push_back(beat);
            end
        end
    endfunction

    function automatic void predict_panel_item(logic [MODE_W-1:0] mode,
                                               logic [IN_DATA_W-1:0] data);
        int prow;
        int pcol;
        prow = data[4:0];
        pcol = data[9:5];
        case (mode)
            MODE_WRITE:
                // writes land in the frame not on display; off-panel ones drop
                if (prow < PANEL_SIDE && pcol < PANEL_SIDE)
                    frame_mem[(shown_frame ? 0 : FRAME_PIXELS) + prow * PANEL_SIDE + pcol] =
                        {data[17:10], data[25:18], data[33:26]};
            MODE_SWAP:
                swap_armed = 1'b1;
            MODE_TICK:
                run_scan_tick();
            default:
                ;
        endcase
    endfunction

    function automatic void predict_config(logic [CFG_IDX_W-1:0] idx,
                                           logic [DEPTH_W-1:0] val);
        case (idx)
            CFG_COLOR_DEPTH: pwm_depth  = val;
            CFG_COL_OFFSET:  col_offset = val[OFFS_W-1:0];
            CFG_ROW_OFFSET:  row_offset = val[OFFS_W-1:0];
            default:         ;
        endcase
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Idle cycles before the next beat; flip into or out of a calm stretch now and then
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [IN_DATA_W-1:0] noise_payload();
        return {6'b0, 2'($urandom_range(0, 3)), 32'($urandom)};
    endfunction

    function automatic panel_item_t write_item(int prow, int pcol, int red, int green,
                                               int blue);
        return {MODE_WRITE, 6'b0, LEVEL_W'(blue), LEVEL_W'(green), LEVEL_W'(red),
                COORD_W'(pcol), COORD_W'(prow)};
    endfunction

    function automatic int pick_coord();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(PANEL_SIDE, COORD_MAX)
                                           : $urandom_range(0, PANEL_SIDE - 1);
    endfunction

    // Favor levels near the low PWM steps so thresholds are crossed often
    function automatic int pick_level();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 4);
            3:       return 8'hFF;
            4:       return 8'h00;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic panel_item_t random_panel_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return write_item(pick_coord(), pick_coord(), pick_level(), pick_level(),
                              pick_level());
        if (sel < 57)
            return {MODE_SWAP, noise_payload()};
        if (sel < 60)
            return {MODE_UNUSED, noise_payload()};
        return {MODE_TICK, noise_payload()};
    endfunction

    task automatic push_item(panel_item_t item);
        pending_items.push_back(item);
        items_pushed++;
    endtask

    // Call at a falling edge; returns at the falling edge after the beat is taken
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DEPTH_W-1:0] val);
        int target;
        target = cfg_beats + 1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (cfg_beats != target);
    endtask

    task automatic program_registers(int depth, int col, int row);
        write_register(CFG_UNUSED, DEPTH_W'($urandom));
        write_register(CFG_COLOR_DEPTH, DEPTH_W'(depth));
        // upper data bits are don't-care for the offsets; randomize them
        write_register(CFG_COL_OFFSET, DEPTH_W'(($urandom_range(0, 7) << OFFS_W) | col));
        write_register(CFG_ROW_OFFSET, DEPTH_W'(($urandom_range(0, 7) << OFFS_W) | row));
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every line word has come back,
    // then let the block settle.
    task automatic wait_drained();
        do @(negedge clk); while (items_taken != items_pushed || expected_lines.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sender: offer queued items at the falling edge, hold each until taken
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || in_fire)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                s_axis_tuser  <= next_item.mode;
                s_axis_tdata  <= next_item.data;
                s_axis_tvalid <= 1'b1;
                in_gap = draw_gap(in_calm);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls after each beat, plus one long hold-off while
    // a backlog of items is waiting, so the block backs up into its input.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!long_hold_done && lines_seen >= 300 && items_pushed - items_taken > 20)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (out_fire)
        begin
            out_gap = draw_gap(out_calm);
            if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: predict on every accepted input or config beat, check every
    // accepted output beat against the oldest expected line word.
    always @(posedge clk)
    begin
        in_fire  <= s_axis_tvalid && s_axis_tready;
        out_fire <= m_axis_tvalid && m_axis_tready;
        if (cfg_valid && cfg_ready)
        begin
            predict_config(cfg_index, cfg_data);
            cfg_beats++;
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_panel_item(s_axis_tuser, s_axis_tdata);
            items_taken++;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            lines_seen++;
            if (expected_lines.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none, actual %h tlast %b",
                             $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want_beat = expected_lines.pop_front();
                check_field("tile_index", want_beat.tile, m_axis_tdata[3:0]);
                check_field("line_word",  want_beat.line, m_axis_tdata[67:4]);
                check_field("scan_row",   want_beat.row,  m_axis_tdata[71:68]);
                check_field("color_step", want_beat.step, m_axis_tdata[79:72]);
                check_field("last_tile",  want_beat.last, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        foreach (frame_mem[i])
            frame_mem[i] = '0;
        shown_frame  = 1'b0;
        swap_armed   = 1'b0;
        scan_row_cnt = 0;
        pwm_step     = 0;
        pwm_depth    = DEPTH_RESET;
        col_offset   = COL_OFF_RESET;
        row_offset   = ROW_OFF_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: depth one keeps the step at zero, so ten ticks wrap the
        // step and apply the swap.
        program_registers(1, 0, 32);
        @(posedge clk);
        push_item(write_item(0, 0, 8'hFF, 8'h00, 8'h00));
        push_item(write_item(PANEL_SIDE - 1, PANEL_SIDE - 1, 8'h00, 8'hFF, 8'h01));
        push_item(write_item(0, PANEL_SIDE - 1, 8'h01, 8'h01, 8'hFF));
        push_item(write_item(PANEL_SIDE - 1, 0, 8'h80, 8'h55, 8'hAA));
        // off-panel writes must leave the frame alone
        push_item(write_item(COORD_MAX, COORD_MAX, 8'hFF, 8'hFF, 8'hFF));
        push_item(write_item(PANEL_SIDE, 5, 8'hFF, 8'hFF, 8'hFF));
        push_item(write_item(5, PANEL_SIDE, 8'hFF, 8'hFF, 8'hFF));
        push_item(write_item(1, 0, 8'hFF, 8'hFF, 8'hFF));
        push_item({MODE_UNUSED, noise_payload()});
        // second request while one is pending
        push_item({MODE_SWAP, noise_payload()});
        push_item({MODE_SWAP, noise_payload()});
        repeat (11) push_item({MODE_TICK, noise_payload()});
        push_item(write_item(10, 10, 8'hFF, 8'hFF, 8'hFF));
        push_item({MODE_TICK, noise_payload()});

        // Random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            program_registers(phase_depth[p], phase_col[p], phase_row[p]);
            @(posedge clk);
            for (int k = 0; k < phase_items[p]; k++)
            begin
                // pause the sender once until everything has come back
                if (p == 0 && k == phase_items[p] / 2)
                begin
                    wait_drained();
                    @(posedge clk);
                end
                push_item(random_panel_item());
            end
        end

        wait_drained();
        if (mismatches == 0 && expected_lines.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
